// ----- hw/rtl/slva_pkg.sv -----
package slva_pkg;

  localparam int IW     = 7;   // vertex / entry index
  localparam int PW     = 20;  // Q12.8 coordinate
  localparam int NW     = 16;  // Q1.14 unit component
  localparam int CW     = 8;   // color channel
  localparam int DW     = 21;  // vertex - light difference
  localparam int SQW    = 42;  // squared length
  localparam int DSW    = 21;  // distance
  localparam int QW     = 15;  // unit quotient magnitude
  localparam int RW     = 23;  // divider remainder
  localparam int FW     = 17;  // Q.16 factors, at most 1.0
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 60;

  localparam logic OP_LIGHT = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef enum logic [CFG_IW-1:0] {
    REG_LIGHT_POSITION  = 3'd0,
    REG_LIGHT_DIRECTION = 3'd1,
    REG_LIGHT_COLOR     = 3'd2,
    REG_CONE_COS_MIN    = 3'd3,
    REG_CONE_SCALE      = 3'd4,
    REG_RANGE_MAX       = 3'd5,
    REG_RANGE_SCALE     = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0][PW-1:0] pos;
    logic [2:0][NW-1:0] dir;
    logic [2:0][CW-1:0] color;
    logic signed [15:0] cos_min;
    logic [23:0]        cone_scale;
    logic [18:0]        range_max;
    logic [23:0]        range_scale;
  } light_cfg_t;

  typedef struct packed {
    logic [2:0][PW-1:0] pos;
    logic [2:0][NW-1:0] nrm;
  } vertex_t;

  typedef struct packed {
    logic               done;
    logic [2:0][CW-1:0] color;
  } math_res_t;

endpackage

// ----- hw/rtl/slva_in_if.sv -----
interface slva_in_if;
  import slva_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic [IW-1:0]        vertex_index;
  logic signed [PW-1:0] pos_x;
  logic signed [PW-1:0] pos_y;
  logic signed [PW-1:0] pos_z;
  logic signed [NW-1:0] normal_x;
  logic signed [NW-1:0] normal_y;
  logic signed [NW-1:0] normal_z;
  logic                 last;

  modport source (output valid, operation, vertex_index, pos_x, pos_y, pos_z,
                  normal_x, normal_y, normal_z, last, input ready);
  modport sink (input valid, operation, vertex_index, pos_x, pos_y, pos_z,
                normal_x, normal_y, normal_z, last, output ready);
endinterface

// ----- hw/rtl/slva_out_if.sv -----
interface slva_out_if;
  import slva_pkg::*;
  logic          valid;
  logic          ready;
  logic [IW-1:0] entry_index;
  logic [CW-1:0] red;
  logic [CW-1:0] green;
  logic [CW-1:0] blue;

  modport source (output valid, entry_index, red, green, blue, input ready);
  modport sink (input valid, entry_index, red, green, blue, output ready);
endinterface

// ----- hw/rtl/spot_light_vertex_accumulate.sv -----
// A lit vertex reaches the output after 3 squares, a 21-step square root, a
//   15-step divider (cut short at zero distance), 13 multiplier steps and a done state.
// Flow: one item at a time; the next item can be taken once the result is
//   registered, and a clear on a lit map sweeps all VERTEX_COUNT entries.
// Reset: synchronous active-low; config regs to their defaults, map counts as
//   black, the lightmap RAM itself is not initialized.
module spot_light_vertex_accumulate #(
  parameter int VERTEX_COUNT = 128
) (
  input  logic                          clk,
  input  logic                          rst_n,
  slva_in_if.sink                       in_item,
  slva_out_if.source                    out_item,
  input  logic                          cfg_we,
  input  logic [slva_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [slva_pkg::CFG_DW-1:0]   cfg_data
);
  import slva_pkg::*;

  localparam int AW = $clog2(VERTEX_COUNT);
  localparam int XW = (AW > IW) ? AW : IW;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CALC  = 3'b010,
    S_CLEAR = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // config registers
  logic [59:0]        lpos_r;
  logic [47:0]        ldir_r;
  logic [23:0]        lcol_r;
  logic signed [15:0] cmin_r;
  logic [23:0]        cscale_r;
  logic [18:0]        rmax_r;
  logic [23:0]        rscale_r;

  logic          black_r;
  logic [IW-1:0] idx_r;
  logic          last_r;
  logic [AW-1:0] clr_r;

  logic          out_valid_r;
  logic [IW-1:0] out_idx_r;
  logic [23:0]   out_col_r;

  light_cfg_t    cfg;
  vertex_t       vtx;
  math_res_t     mres;

  logic          in_fire, in_range, start, finish, clr_done;
  logic [XW-1:0] idx_x;
  logic [AW-1:0] addr;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [23:0]   ram_wdata, ram_rdata, new_col;

  assign cfg.pos         = lpos_r;
  assign cfg.dir         = ldir_r;
  assign cfg.color       = lcol_r;
  assign cfg.cos_min     = cmin_r;
  assign cfg.cone_scale  = cscale_r;
  assign cfg.range_max   = rmax_r;
  assign cfg.range_scale = rscale_r;

  assign vtx.pos = {in_item.pos_z, in_item.pos_y, in_item.pos_x};
  assign vtx.nrm = {in_item.normal_z, in_item.normal_y, in_item.normal_x};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lpos_r   <= '0;
      ldir_r   <= '0;
      lcol_r   <= '0;
      cmin_r   <= 16'sh8000;
      cscale_r <= 24'h010000;
      rmax_r   <= '0;
      rscale_r <= 24'h010000;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_LIGHT_POSITION:  lpos_r   <= cfg_data[59:0];
        REG_LIGHT_DIRECTION: ldir_r   <= cfg_data[47:0];
        REG_LIGHT_COLOR:     lcol_r   <= cfg_data[23:0];
        REG_CONE_COS_MIN:    cmin_r   <= $signed(cfg_data[15:0]);
        REG_CONE_SCALE:      cscale_r <= cfg_data[23:0];
        REG_RANGE_MAX:       rmax_r   <= cfg_data[18:0];
        REG_RANGE_SCALE:     rscale_r <= cfg_data[23:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  assign in_item.ready = (state_r == S_IDLE);
  assign in_fire       = in_item.valid && in_item.ready;
  assign in_range      = {25'd0, in_item.vertex_index} < 32'(VERTEX_COUNT);
  assign start         = in_fire && (in_item.operation == OP_LIGHT) && in_range;

  // the result may sit in the output register while the next item runs;
  // it only blocks the write-back of that next item
  assign finish   = (state_r == S_CALC) && mres.done && (!out_valid_r || out_item.ready);
  assign clr_done = (clr_r == AW'(VERTEX_COUNT - 1));

  assign idx_x = XW'(idx_r);
  assign addr  = idx_x[AW-1:0];

  // first pass after a clear replaces, later passes add with saturation
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [8:0] s;
      s = {1'b0, ram_rdata[8*c +: 8]} + {1'b0, mres.color[c]};
      new_col[8*c +: 8] = black_r ? mres.color[c] : (s[8] ? 8'hFF : s[7:0]);
    end
  end

  assign ram_we    = finish || (state_r == S_CLEAR);
  assign ram_waddr = (state_r == S_CLEAR) ? clr_r : addr;
  assign ram_wdata = (state_r == S_CLEAR) ? 24'd0 : new_col;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_CALC;
        end else if (in_fire && (in_item.operation == OP_CLEAR) && !black_r) begin
          state_nxt = S_CLEAR;
        end
      end
      S_CALC:  if (finish) state_nxt = S_IDLE;
      S_CLEAR: if (clr_done) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      black_r     <= 1'b1;
      out_valid_r <= 1'b0;
      clr_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (finish) begin
        out_valid_r <= 1'b1;
        if (last_r) black_r <= 1'b0;
      end else if (out_valid_r && out_item.ready) begin
        out_valid_r <= 1'b0;
      end
      // out-of-range vertex still closes the pass
      if (in_fire && (in_item.operation == OP_LIGHT) && !in_range && in_item.last) begin
        black_r <= 1'b0;
      end
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + AW'(1);
        if (clr_done) black_r <= 1'b1;
      end else begin
        clr_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      idx_r  <= in_item.vertex_index;
      last_r <= in_item.last;
    end
    if (finish) begin
      out_idx_r <= idx_r;
      out_col_r <= new_col;
    end
  end

  assign out_item.valid       = out_valid_r;
  assign out_item.entry_index = out_idx_r;
  assign out_item.red         = out_col_r[7:0];
  assign out_item.green       = out_col_r[15:8];
  assign out_item.blue        = out_col_r[23:16];

  // read address is held for the whole computation, so the registered
  // read data is current at write-back
  slva_ram #(
    .WIDTH (24),
    .DEPTH (VERTEX_COUNT)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  slva_math u_math (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .ack   (finish),
    .cfg   (cfg),
    .vtx   (vtx),
    .res   (mres)
  );

  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    mres.done |-> (state_r == S_CALC))
    else $error("math result outside a computation");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> ((state_r == S_CALC) && !mres.done))
    else $error("accepted vertex did not start the math unit");

  a_clear_black: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_CLEAR) && clr_done) |=> black_r)
    else $error("clear sweep did not mark map black");

  a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("write-back did not present a result");

endmodule

// ----- hw/rtl/slva_ram.sv -----
module slva_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- hw/rtl/slva_math.sv -----
module slva_math (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   ack,
  input  slva_pkg::light_cfg_t   cfg,
  input  slva_pkg::vertex_t      vtx,
  output slva_pkg::math_res_t    res
);
  import slva_pkg::*;

  typedef enum logic [5:0] {
    M_IDLE = 6'b000001,
    M_SQ   = 6'b000010,
    M_ROOT = 6'b000100,
    M_DIV  = 6'b001000,
    M_MUL  = 6'b010000,
    M_DONE = 6'b100000
  } mstate_t;

  localparam logic [4:0] SQ_LAST   = 5'd2;
  localparam logic [4:0] ROOT_LAST = 5'd20;
  localparam logic [4:0] DIV_LAST  = 5'd14;
  localparam logic [4:0] ST_NDOT   = 5'd3;
  localparam logic [4:0] ST_CONE   = 5'd6;
  localparam logic [4:0] ST_RNG    = 5'd7;
  localparam logic [4:0] ST_F1     = 5'd8;
  localparam logic [4:0] ST_F      = 5'd9;
  localparam logic [4:0] ST_COL    = 5'd10;
  localparam logic [4:0] MUL_LAST  = 5'd12;

  localparam logic signed [58:0] LIM44 = 59'sd1 <<< 44;
  localparam logic signed [58:0] LIM24 = 59'sd1 <<< 24;
  localparam logic signed [33:0] LIM28 = 34'sd1 <<< 28;
  localparam logic [FW-1:0]      ONE   = FW'(1) << 16;

  mstate_t    state_r, state_nxt;
  logic [4:0] step_r, step_nxt;

  logic signed [DW-1:0]  d_r   [3];
  logic signed [NW-1:0]  nrm_r [3];
  logic [SQW-1:0]        sq_r, rres_r, rbit_r;
  logic [RW-1:0]         drem_r [3];
  logic [QW-1:0]         q_r    [3];
  logic [2:0]            neg_r;
  logic signed [32:0]    cdot_r, ndot_r;
  logic signed [33:0]    a_r;
  logic signed [21:0]    rd_r;
  logic [FW-1:0]         cone_r, rng_r, dif_r, f1_r, f_r;
  logic [2:0][CW-1:0]    col_r;

  logic [DSW-1:0]        dlen;
  logic [SQW:0]          trial;
  logic [DW-1:0]         mag [3];
  logic signed [NW-1:0]  u   [3];
  logic signed [33:0]    nn;
  logic [1:0]            lane;
  logic signed [33:0]    ma;
  logic signed [24:0]    mb;
  logic signed [58:0]    mp;

  assign dlen  = rres_r[DSW-1:0];
  assign trial = {1'b0, rres_r} + {1'b0, rbit_r};
  assign nn    = -34'(ndot_r);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = d_r[i][DW-1] ? DW'(-d_r[i]) : DW'(d_r[i]);
      u[i]   = neg_r[i] ? -$signed({1'b0, q_r[i]}) : $signed({1'b0, q_r[i]});
    end
  end

  // one shared multiplier, operands picked by phase and step
  always_comb begin
    ma   = '0;
    mb   = '0;
    lane = step_r[1:0];
    case (state_r)
      M_SQ: begin
        ma = 34'(d_r[lane]);
        mb = 25'(d_r[lane]);
      end
      M_MUL: begin
        if (step_r inside {[5'd0:5'd2]}) begin
          ma = 34'(u[lane]);
          mb = 25'($signed(cfg.dir[lane]));
        end else if (step_r inside {[ST_NDOT:ST_NDOT + 5'd2]}) begin
          lane = 2'(step_r - ST_NDOT);
          ma   = 34'(nrm_r[lane]);
          mb   = 25'(u[lane]);
        end else if (step_r == ST_CONE) begin
          ma = a_r;
          mb = 25'({1'b0, cfg.cone_scale});
        end else if (step_r == ST_RNG) begin
          ma = 34'(rd_r);
          mb = 25'({1'b0, cfg.range_scale});
        end else if (step_r == ST_F1) begin
          ma = 34'({1'b0, dif_r});
          mb = 25'({1'b0, cone_r});
        end else if (step_r == ST_F) begin
          ma = 34'({1'b0, f1_r});
          mb = 25'({1'b0, rng_r});
        end else begin
          lane = 2'(step_r - ST_COL);
          ma   = 34'({1'b0, cfg.color[lane]});
          mb   = 25'({1'b0, f_r});
        end
      end
      default: ;
    endcase
  end

  assign mp = ma * mb;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r + 5'd1;
    case (state_r)
      M_IDLE: begin
        step_nxt = '0;
        if (start) state_nxt = M_SQ;
      end
      M_SQ: begin
        if (step_r == SQ_LAST) begin
          state_nxt = M_ROOT;
          step_nxt  = '0;
        end
      end
      M_ROOT: begin
        if (step_r == ROOT_LAST) begin
          state_nxt = M_DIV;
          step_nxt  = '0;
        end
      end
      M_DIV: begin
        if (dlen == '0) begin
          state_nxt = M_DONE;
        end else if (step_r == DIV_LAST) begin
          state_nxt = M_MUL;
          step_nxt  = '0;
        end
      end
      M_MUL: begin
        if (step_r == MUL_LAST) state_nxt = M_DONE;
      end
      M_DONE: begin
        step_nxt = '0;
        if (ack) state_nxt = M_IDLE;
      end
      default: begin
        state_nxt = M_IDLE;
        step_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      M_IDLE: begin
        for (int i = 0; i < 3; i++) begin
          d_r[i]   <= DW'($signed(vtx.pos[i])) - DW'($signed(cfg.pos[i]));
          nrm_r[i] <= $signed(vtx.nrm[i]);
        end
        sq_r   <= '0;
        rres_r <= '0;
        rbit_r <= SQW'(1) << (SQW - 2);
        cdot_r <= '0;
        ndot_r <= '0;
      end
      M_SQ: sq_r <= sq_r + mp[SQW-1:0];
      M_ROOT: begin
        // one result bit per step, sq_r holds the remainder
        if ({1'b0, sq_r} >= trial) begin
          sq_r   <= sq_r - trial[SQW-1:0];
          rres_r <= (rres_r >> 1) + rbit_r;
        end else begin
          rres_r <= rres_r >> 1;
        end
        rbit_r <= rbit_r >> 2;
        for (int i = 0; i < 3; i++) begin
          drem_r[i] <= RW'(mag[i]);
          q_r[i]    <= '0;
          neg_r[i]  <= d_r[i][DW-1];
        end
      end
      M_DIV: begin
        if (dlen == '0) begin
          col_r <= '0;
        end else begin
          // |d|/dist <= 1, so the quotient starts at the 2^14 bit
          for (int i = 0; i < 3; i++) begin
            if (drem_r[i] >= RW'(dlen)) begin
              drem_r[i] <= RW'((drem_r[i] - RW'(dlen)) << 1);
              q_r[i]    <= {q_r[i][QW-2:0], 1'b1};
            end else begin
              drem_r[i] <= drem_r[i] << 1;
              q_r[i]    <= {q_r[i][QW-2:0], 1'b0};
            end
          end
        end
      end
      M_MUL: begin
        if (step_r inside {[5'd0:5'd2]}) begin
          cdot_r <= cdot_r + 33'(mp);
        end else if (step_r inside {[ST_NDOT:ST_NDOT + 5'd2]}) begin
          ndot_r <= ndot_r + 33'(mp);
        end else if (step_r == ST_CONE) begin
          if (mp < 0)          cone_r <= '0;
          else if (mp > LIM44) cone_r <= ONE;
          else                 cone_r <= mp[44:28];
        end else if (step_r == ST_RNG) begin
          if (mp < 0)          rng_r <= '0;
          else if (mp > LIM24) rng_r <= ONE;
          else                 rng_r <= mp[24:8];
          if (nn < 0)          dif_r <= '0;
          else if (nn > LIM28) dif_r <= ONE;
          else                 dif_r <= nn[28:12];
        end else if (step_r == ST_F1) begin
          f1_r <= mp[32:16];
        end else if (step_r == ST_F) begin
          f_r <= mp[32:16];
        end else begin
          col_r[lane] <= mp[23:16];
        end
        if (step_r == ST_NDOT) begin
          a_r  <= 34'(cdot_r) - (34'(cfg.cos_min) <<< 14);
          rd_r <= $signed({3'b000, cfg.range_max}) - $signed({1'b0, dlen});
        end
      end
      default: ;
    endcase
  end

  assign res.done  = (state_r == M_DONE);
  assign res.color = col_r;

endmodule

// ----- tb/tb_spot_light_vertex_accumulate.sv -----
`timescale 1ns / 100ps

module tb_spot_light_vertex_accumulate;
  import slva_pkg::*;

  // cycles with no item moving on either side before the run is called hung
  localparam int STALL_LIMIT = 6000;
  // a clear on a lit map sweeps 128 entries and gives no result; this covers
  // both that sweep and the lit path with margin
  localparam int SETTLE = 300;
  localparam int RANDOM_ITEMS = 1750;
  localparam int N_PHASES = 8;

  typedef struct {
    logic                 op;
    logic [IW-1:0]        idx;
    logic signed [PW-1:0] p[3];
    logic signed [NW-1:0] n[3];
    logic                 last;
  } vtx_item_t;

  // Shadow of the block: its registers, the lightmap and the black flag, plus
  // the queue of entry updates still to come out.
  class light_scoreboard;
    logic [59:0]        lpos;
    logic [47:0]        ldir;
    logic [23:0]        lcolor;
    logic signed [15:0] cos_min;
    logic [23:0]        cone_scale;
    logic [18:0]        range_max;
    logic [23:0]        range_scale;
    logic [23:0]        lightmap[128];
    bit                 written[128];
    bit                 map_black;
    logic [31:0]        pending_updates[$];
    int                 errors;

    function void reset_state();
      lpos = '0; ldir = '0; lcolor = '0;
      cos_min = 16'sh8000; cone_scale = 24'd65536;
      range_max = '0; range_scale = 24'd65536;
      map_black = 1; errors = 0;
      foreach (written[i]) written[i] = 0;
    endfunction

    function void write_reg(cfg_reg_t r, logic [CFG_DW-1:0] v);
      case (r)
        REG_LIGHT_POSITION:  lpos = v[59:0];
        REG_LIGHT_DIRECTION: ldir = v[47:0];
        REG_LIGHT_COLOR:     lcolor = v[23:0];
        REG_CONE_COS_MIN:    cos_min = v[15:0];
        REG_CONE_SCALE:      cone_scale = v[23:0];
        REG_RANGE_MAX:       range_max = v[18:0];
        REG_RANGE_SCALE:     range_scale = v[23:0];
        default: ;
      endcase
    endfunction

    function longint unsigned root(longint unsigned x);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function longint clamp(longint v, longint hi);
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
    endfunction

    // Q1.14 unit component, truncated toward zero
    function longint unit_of(longint d, longint dlen);
      longint q;
      q = ((d < 0 ? -d : d) * 16384) / dlen;
      return d < 0 ? -q : q;
    endfunction

    function logic [23:0] shade(vtx_item_t it);
      longint d[3], u[3], dir_c, cdot, ndot, dlen, cone, rng, dif, f, ch;
      longint unsigned sq;
      logic [23:0] col;
      sq = 0; cdot = 0; ndot = 0; col = '0;
      for (int i = 0; i < 3; i++) begin
        d[i] = longint'(it.p[i]) - longint'($signed(lpos[20*i +: 20]));
        sq += d[i] * d[i];
      end
      dlen = root(sq);
      if (dlen == 0) return col;  // light sits on the vertex: black
      for (int i = 0; i < 3; i++) begin
        u[i] = unit_of(d[i], dlen);
        dir_c = longint'($signed(ldir[16*i +: 16]));
        cdot += u[i] * dir_c;
        ndot += longint'(it.n[i]) * u[i];
      end
      cone = clamp((cdot - longint'(cos_min) * 16384) * longint'(cone_scale),
                   64'sd1 << 44) >>> 28;
      rng = clamp((longint'(range_max) - dlen) * longint'(range_scale),
                  64'sd1 << 24) >>> 8;
      dif = clamp(-ndot, 64'sd1 << 28) >>> 12;
      f = (((dif * cone) >>> 16) * rng) >>> 16;
      for (int i = 0; i < 3; i++) begin
        ch = (longint'(lcolor[8*i +: 8]) * f) >>> 16;
        col[8*i +: 8] = ch > 255 ? 8'd255 : ch[7:0];
      end
      return col;
    endfunction

    function void note_item(vtx_item_t it);
      logic [23:0] col, res;
      int s;
      if (it.op == OP_CLEAR) begin
        if (!map_black) begin
          foreach (lightmap[i]) begin
            lightmap[i] = '0;
            written[i] = 1;
          end
          map_black = 1;
        end
        return;
      end
      col = shade(it);
      if (map_black) begin
        res = col;
      end else begin
        for (int i = 0; i < 3; i++) begin
          s = lightmap[it.idx][8*i +: 8] + col[8*i +: 8];
          res[8*i +: 8] = s > 255 ? 8'd255 : s[7:0];
        end
      end
      lightmap[it.idx] = res;
      written[it.idx] = 1;
      if (it.last) map_black = 0;
      pending_updates.push_back({1'b0, it.idx, res});
    endfunction

    function void check_update(logic [IW-1:0] idx, logic [7:0] r, logic [7:0] g,
                               logic [7:0] b);
      logic [31:0] e;
      if (pending_updates.size() == 0) begin
        $error("unexpected result: entry_index %0d rgb %0d %0d %0d", idx, r, g, b);
        errors++;
        return;
      end
      e = pending_updates.pop_front();
      if (idx !== e[30:24]) begin
        $error("entry_index: expected %0d actual %0d", e[30:24], idx);
        errors++;
      end
      if (r !== e[7:0]) begin
        $error("red: expected %0d actual %0d", e[7:0], r);
        errors++;
      end
      if (g !== e[15:8]) begin
        $error("green: expected %0d actual %0d", e[15:8], g);
        errors++;
      end
      if (b !== e[23:16]) begin
        $error("blue: expected %0d actual %0d", e[23:16], b);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  slva_in_if  vin();
  slva_out_if vout();

  spot_light_vertex_accumulate dut (
    .clk(clk), .rst_n(rst_n), .in_item(vin.sink), .out_item(vout.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  light_scoreboard sb;
  int  send_idle_pct;   // chance per cycle that the sender holds off
  int  recv_stall_pct;  // chance per cycle that the receiver drops ready
  int  quiet_cycles;
  bit  timed_out;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Result side: random back-pressure, check every accepted result.
  always @(posedge clk) begin
    if (!rst_n) begin
      vout.ready <= 1'b0;
    end else begin
      if (vout.valid && vout.ready)
        sb.check_update(vout.entry_index, vout.red, vout.green, vout.blue);
      vout.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Hang detector: counts cycles in which nothing moves on either channel.
  always @(posedge clk) begin
    if (!rst_n || (vin.valid && vin.ready) || (vout.valid && vout.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT && !timed_out) begin
        timed_out <= 1'b1;
        $display("tb_spot_light_vertex_accumulate: errors");
        $finish;
      end
    end
  end

  // Idle only: block must have nothing in flight.
  task automatic write_cfg(cfg_reg_t r, logic [CFG_DW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(posedge clk);
    sb.write_reg(r, v);
  endtask

  // Wait until every expected result is out, then let a clear sweep finish.
  task automatic settle();
    vin.valid <= 1'b0;
    cfg_we    <= 1'b0;
    while (sb.pending_updates.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Offer one item, with random idle ahead of it, and hold until taken.
  task automatic send(vtx_item_t it);
    // adding into an entry never written since reset is not allowed
    if (it.op == OP_LIGHT && !sb.map_black && !sb.written[it.idx]) begin
      do it.idx = IW'($urandom_range(127)); while (!sb.written[it.idx]);
    end
    while ($urandom_range(99) < send_idle_pct) begin
      vin.valid <= 1'b0;
      @(posedge clk);
    end
    vin.valid        <= 1'b1;
    vin.operation    <= it.op;
    vin.vertex_index <= it.idx;
    vin.pos_x    <= it.p[0];
    vin.pos_y    <= it.p[1];
    vin.pos_z    <= it.p[2];
    vin.normal_x <= it.n[0];
    vin.normal_y <= it.n[1];
    vin.normal_z <= it.n[2];
    vin.last     <= it.last;
    @(posedge clk);
    while (!vin.ready) @(posedge clk);
    sb.note_item(it);
  endtask

  function automatic vtx_item_t clear_item();
    vtx_item_t it;
    it.op = OP_CLEAR; it.idx = IW'($urandom); it.last = 1'($urandom);
    for (int i = 0; i < 3; i++) begin
      it.p[i] = PW'($urandom);
      it.n[i] = NW'($urandom);
    end
    return it;
  endfunction

  // Any bit pattern in any field.
  function automatic vtx_item_t noise_item();
    vtx_item_t it;
    it = clear_item();
    it.op = 1'($urandom);
    return it;
  endfunction

  // Vertex placed near the light, normal mostly facing back toward it.
  function automatic vtx_item_t lit_vertex(logic [IW-1:0] idx, logic last);
    vtx_item_t it;
    longint off[3], len, span, nv;
    span = sb.range_max > 64 ? sb.range_max / 2 : 64;
    for (int i = 0; i < 3; i++) begin
      off[i] = longint'($urandom_range(32'(2 * span))) - span;
      it.p[i] = PW'(longint'($signed(sb.lpos[20*i +: 20])) + off[i]);
    end
    len = sb.root(off[0]*off[0] + off[1]*off[1] + off[2]*off[2]);
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(9) < 7 && len != 0) begin
        nv = -(off[i] * 16384) / len + longint'($urandom_range(2000)) - 1000;
        if (nv > 16384) nv = 16384;
        if (nv < -16384) nv = -16384;
        it.n[i] = NW'(nv);
      end else begin
        it.n[i] = NW'(longint'($urandom_range(32768)) - 16384);
      end
    end
    it.op = OP_LIGHT; it.idx = idx; it.last = last;
    return it;
  endfunction

  // One lighting setup per phase; phases 1 and 2 pin the extremes.
  task automatic setup_light(int phase);
    logic [CFG_DW-1:0] v;
    int rm;
    case (phase)
      1: begin
        write_cfg(REG_LIGHT_POSITION, CFG_DW'({20'h80000, 20'h80000, 20'h80000}));
        write_cfg(REG_LIGHT_DIRECTION, CFG_DW'({16'h8000, 16'h8000, 16'h8000}));
        write_cfg(REG_LIGHT_COLOR, CFG_DW'(24'h000000));
        write_cfg(REG_CONE_COS_MIN, CFG_DW'(16'h8000));
        write_cfg(REG_CONE_SCALE, CFG_DW'(24'd0));
        write_cfg(REG_RANGE_MAX, CFG_DW'(19'd0));
        write_cfg(REG_RANGE_SCALE, CFG_DW'(24'd0));
      end
      2: begin
        write_cfg(REG_LIGHT_POSITION, CFG_DW'({20'h7ffff, 20'h7ffff, 20'h7ffff}));
        write_cfg(REG_LIGHT_DIRECTION, CFG_DW'({16'h7fff, 16'h7fff, 16'h7fff}));
        write_cfg(REG_LIGHT_COLOR, CFG_DW'(24'hffffff));
        write_cfg(REG_CONE_COS_MIN, CFG_DW'(16'h4000));
        write_cfg(REG_CONE_SCALE, CFG_DW'(24'hffffff));
        write_cfg(REG_RANGE_MAX, CFG_DW'(19'h7ffff));
        write_cfg(REG_RANGE_SCALE, CFG_DW'(24'hffffff));
      end
      default: begin
        v = CFG_DW'({$urandom, $urandom});
        write_cfg(REG_LIGHT_POSITION, v);
        write_cfg(REG_LIGHT_DIRECTION, CFG_DW'({16'($urandom_range(32768) - 16384),
                                                16'($urandom_range(32768) - 16384),
                                                16'($urandom_range(32768) - 16384)}));
        write_cfg(REG_LIGHT_COLOR, CFG_DW'($urandom));
        // omni some of the time, a real cone otherwise
        write_cfg(REG_CONE_COS_MIN, CFG_DW'(phase % 3 == 0 ? 16'h8000 :
                                            16'($urandom_range(49152) - 32768)));
        write_cfg(REG_CONE_SCALE, CFG_DW'($urandom_range(1 << 20)));
        rm = $urandom_range(524287, 256);
        write_cfg(REG_RANGE_MAX, CFG_DW'(rm));
        write_cfg(REG_RANGE_SCALE, CFG_DW'($urandom_range(1 << 14, 16)));
      end
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic directed();
    vtx_item_t it;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_cfg(REG_LIGHT_POSITION, CFG_DW'({20'd1000, 20'd0, -20'sd1000}));
    write_cfg(REG_LIGHT_DIRECTION, CFG_DW'({16'sd16384, 16'd0, 16'd0}));
    write_cfg(REG_LIGHT_COLOR, CFG_DW'(24'hc08040));
    write_cfg(REG_CONE_COS_MIN, CFG_DW'(16'h8000));
    write_cfg(REG_CONE_SCALE, CFG_DW'(24'd65536));
    write_cfg(REG_RANGE_MAX, CFG_DW'(19'd200000));
    write_cfg(REG_RANGE_SCALE, CFG_DW'(24'd4096));
    cfg_we <= 1'b0;
    // clear while already black: nothing changes
    send(clear_item());
    // vertex sitting on the light: black
    it = lit_vertex(7'd0, 1'b0);
    it.p[0] = -20'sd1000; it.p[1] = 0; it.p[2] = 20'sd1000;
    send(it);
    // field extremes
    it = lit_vertex(7'd127, 1'b0);
    it.p[0] = -20'sd524288; it.p[1] = 20'sd524287; it.p[2] = -20'sd524288;
    it.n[0] = 16'sd16384; it.n[1] = -16'sd16384; it.n[2] = 16'sd16384;
    send(it);
    it.p[0] = 20'sd524287; it.p[1] = -20'sd524288; it.p[2] = 20'sd524287;
    it.n[0] = -16'sd16384; it.n[1] = 16'sd16384; it.n[2] = -16'sd16384;
    send(it);
    for (int i = 0; i < 6; i++) send(lit_vertex(7'(i + 1), i == 5));
    // second pass adds onto the first, saturating
    for (int i = 0; i < 6; i++) send(lit_vertex(7'(i + 1), i == 5));
    send(clear_item());
    send(clear_item());
    for (int i = 0; i < 4; i++) send(lit_vertex(7'(i + 1), i == 3));
    settle();
  endtask

  initial begin
    int per_phase, sent, n;
    sb = new();
    sb.reset_state();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    vin.valid = 1'b0;
    vin.operation = OP_LIGHT;
    vin.vertex_index = '0;
    vin.pos_x = '0; vin.pos_y = '0; vin.pos_z = '0;
    vin.normal_x = '0; vin.normal_y = '0; vin.normal_z = '0;
    vin.last = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed();

    per_phase = RANDOM_ITEMS / N_PHASES;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      setup_light(ph);
      // rotate the pacing: none, slow sender, slow receiver, both
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      sent = 0;
      while (sent < per_phase) begin
        if ($urandom_range(9) == 0) begin
          send(noise_item());
          sent++;
        end else begin
          if ($urandom_range(5) == 0) send(clear_item());
          // one light pass over a small patch; sometimes cut short with no last
          n = $urandom_range(30, 1);
          for (int v = 0; v < n; v++)
            send(lit_vertex(IW'($urandom_range(127)),
                            v == n - 1 && $urandom_range(7) != 0));
          sent += n;
        end
        // sender holds off until the block has drained
        if (ph == 3 && sent > per_phase / 2 && sent < per_phase / 2 + 31) begin
          vin.valid <= 1'b0;
          while (sb.pending_updates.size() != 0) @(posedge clk);
        end
      end
      settle();
    end

    if (sb.errors == 0 && sb.pending_updates.size() == 0) begin
      $display("tb_spot_light_vertex_accumulate: clean");
    end else begin
      if (sb.pending_updates.size() != 0)
        $error("%0d expected results never arrived", sb.pending_updates.size());
      $display("tb_spot_light_vertex_accumulate: errors");
    end
    $finish;
  end

endmodule
